// ===== design/rotation_matrix_to_quaternion_unit_defines.svh =====
// assertion macros for the rotation matrix to quaternion unit
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define RMQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define RMQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rmq_pkg.sv =====
// shared constants, types and tables for the rotation matrix to quaternion unit
package rmq_pkg;

    localparam int FRAC_BITS_DEF        = 14;
    localparam int RSQRT_ITERATIONS_DEF = 2;
    localparam int WORK_BITS            = 30;
    localparam int IO_W                 = 16;
    // sums of up to four 16-bit operands
    localparam int SUM_W                = 19;
    localparam int Y_W                  = 32;
    localparam int SH_W                 = 7;
    // side band: degenerate flag, branch, shift, three operands and t
    localparam int SIDE_W               = 4*SUM_W+SH_W+3;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } branch_t;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [Y_W-1:0]          rsq_t;

    function automatic logic [9:0] seed_q8(input logic [3:0] idx);
        logic [9:0] v;
        case (idx)
            4'd4:    v = 10'd483;
            4'd5:    v = 10'd437;
            4'd6:    v = 10'd402;
            4'd7:    v = 10'd374;
            4'd8:    v = 10'd351;
            4'd9:    v = 10'd332;
            4'd10:   v = 10'd316;
            4'd11:   v = 10'd302;
            4'd12:   v = 10'd290;
            4'd13:   v = 10'd279;
            4'd14:   v = 10'd269;
            4'd15:   v = 10'd260;
            default: v = 10'd512;
        endcase
        return v;
    endfunction

endpackage

// ===== design/rmq_newton_stage.sv =====
// one newton step of the inverse square root, four register stages
module rmq_newton_stage (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [rmq_pkg::WORK_BITS-1:0] in_u,
    input  rmq_pkg::rsq_t            in_y,
    input  logic [rmq_pkg::SIDE_W-1:0] in_side,
    output logic                     out_valid,
    output logic [rmq_pkg::WORK_BITS-1:0] out_u,
    output rmq_pkg::rsq_t            out_y,
    output logic [rmq_pkg::SIDE_W-1:0] out_side
);
    localparam int WB = rmq_pkg::WORK_BITS;
    localparam int YW = rmq_pkg::Y_W;
    localparam int SW = rmq_pkg::SIDE_W;

    logic [3:0]          v_reg;
    logic [WB-1:0]       u_reg [4];
    logic [YW-1:0]       y_reg [3];
    logic [SW-1:0]       s_reg [4];
    logic [YW-1:0]       sq_reg;
    logic [YW+1:0]       f_reg;
    logic [YW-1:0]       y_out_reg;
    logic [2*YW-1:0]     p_sq;
    logic [YW+WB-1:0]    p_e;
    logic [YW-1:0]       e;
    logic [YW+1:0]       three;
    logic [2*YW+1:0]     p_y;

    assign three = (YW+2)'(3) << WB;
    assign p_sq  = y_reg[0] * y_reg[0];
    assign p_e   = sq_reg * u_reg[1];
    assign e     = YW'(p_e >> WB);
    assign p_y   = y_reg[2] * f_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[0] <= in_u;
            y_reg[0] <= in_y;
            s_reg[0] <= in_side;
            u_reg[1] <= u_reg[0];
            y_reg[1] <= y_reg[0];
            s_reg[1] <= s_reg[0];
            sq_reg   <= YW'(p_sq >> WB);
            u_reg[2] <= u_reg[1];
            y_reg[2] <= y_reg[1];
            s_reg[2] <= s_reg[1];
            f_reg    <= ((YW+2)'(e) >= three) ? '0 : three - (YW+2)'(e);
            u_reg[3] <= u_reg[2];
            s_reg[3] <= s_reg[2];
            y_out_reg <= YW'(p_y >> (WB + 1));
        end
    end

    assign out_valid = v_reg[3];
    assign out_u     = u_reg[3];
    assign out_y     = y_out_reg;
    assign out_side  = s_reg[3];
endmodule

// ===== design/rotation_matrix_to_quaternion_unit.sv =====
// rotation matrix to quaternion, four-branch trace method with newton inverse sqrt
// throughput: one matrix per cycle; a stall freezes the whole pipeline in place
// the inverse square root newton steps set the depth of the pipeline
// reset clears all valid bits; payload registers are not reset
module rotation_matrix_to_quaternion_unit #(
    parameter int RSQRT_ITERATIONS = rmq_pkg::RSQRT_ITERATIONS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_m00,
    input  logic signed [15:0] s_m01,
    input  logic signed [15:0] s_m02,
    input  logic signed [15:0] s_m10,
    input  logic signed [15:0] s_m11,
    input  logic signed [15:0] s_m12,
    input  logic signed [15:0] s_m20,
    input  logic signed [15:0] s_m21,
    input  logic signed [15:0] s_m22,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_quat_w,
    output logic signed [15:0] m_quat_x,
    output logic signed [15:0] m_quat_y,
    output logic signed [15:0] m_quat_z
);
`include "rotation_matrix_to_quaternion_unit_defines.svh"

    localparam int FB = rmq_pkg::FRAC_BITS_DEF;
    localparam int WB = rmq_pkg::WORK_BITS;
    localparam int SW = rmq_pkg::SUM_W;
    localparam int YW = rmq_pkg::Y_W;
    localparam int HW = rmq_pkg::SH_W;
    localparam int DW = rmq_pkg::SIDE_W;
    localparam int NI = RSQRT_ITERATIONS;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: branch selection and operand sums
    logic signed [SW-1:0] one_s, tr, tx, ty, tz, t_sel;
    logic signed [SW-1:0] dwx, dwy, dwz, sxy, sxz, syz;
    logic signed [SW-1:0] o0, o1, o2;
    rmq_pkg::branch_t br;

    assign one_s = SW'(1) <<< FB;
    assign tr  = one_s + SW'(s_m00) + SW'(s_m11) + SW'(s_m22);
    assign tx  = one_s + SW'(s_m00) - SW'(s_m11) - SW'(s_m22);
    assign ty  = one_s + SW'(s_m11) - SW'(s_m00) - SW'(s_m22);
    assign tz  = one_s + SW'(s_m22) - SW'(s_m00) - SW'(s_m11);
    assign dwx = SW'(s_m21) - SW'(s_m12);
    assign dwy = SW'(s_m02) - SW'(s_m20);
    assign dwz = SW'(s_m10) - SW'(s_m01);
    assign sxy = SW'(s_m01) + SW'(s_m10);
    assign sxz = SW'(s_m02) + SW'(s_m20);
    assign syz = SW'(s_m12) + SW'(s_m21);

    always_comb begin
        if (tr > 0) begin
            br = rmq_pkg::BR_W; t_sel = tr; o0 = dwx; o1 = dwy; o2 = dwz;
        end else if (s_m00 > s_m11 && s_m00 > s_m22) begin
            br = rmq_pkg::BR_X; t_sel = tx; o0 = dwx; o1 = sxy; o2 = sxz;
        end else if (s_m11 > s_m22) begin
            br = rmq_pkg::BR_Y; t_sel = ty; o0 = dwy; o1 = sxy; o2 = syz;
        end else begin
            br = rmq_pkg::BR_Z; t_sel = tz; o0 = dwz; o1 = sxz; o2 = syz;
        end
    end

    logic                  v1_reg;
    logic signed [SW-1:0]  t1_reg, o0_1_reg, o1_1_reg, o2_1_reg;
    rmq_pkg::branch_t      br1_reg;

    // stage 2: normalize t to u in [0.25,1)
    logic [SW-1:0] tu;
    logic [4:0]    len;
    logic signed [HW-1:0] sh;
    logic [WB-1:0] u_nrm;
    logic          deg;

    assign tu  = t1_reg;
    assign deg = t1_reg <= 0;
    always_comb begin
        len = '0;
        for (int i = 0; i < SW; i++) begin
            if (tu[i]) len = 5'(i + 1);
        end
        sh = HW'(WB) - HW'(len);
        if (((FB + 32'(len)) & 1) != 0) sh = sh - HW'(1);
        if (sh >= 0) u_nrm = WB'({{(WB){1'b0}}, tu} << sh);
        else         u_nrm = WB'(tu >> (-sh));
    end

    logic                  v2_reg;
    logic [WB-1:0]         u2_reg;
    logic [DW-1:0]         side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg    <= t_sel;
            o0_1_reg  <= o0;
            o1_1_reg  <= o1;
            o2_1_reg  <= o2;
            br1_reg   <= br;
            u2_reg    <= u_nrm;
            // side band: t, offdiag terms, shift, branch, degenerate
            side2_reg <= {deg, br1_reg, sh, o2_1_reg, o1_1_reg, o0_1_reg, t1_reg};
        end
    end

    // stage 3: seed, then newton pipeline
    logic                  vn [NI+1];
    logic [WB-1:0]         un [NI+1];
    rmq_pkg::rsq_t         yn [NI+1];
    logic [DW-1:0]         sn [NI+1];
    logic                  v3_reg;
    logic [WB-1:0]         u3_reg;
    rmq_pkg::rsq_t         y3_reg;
    logic [DW-1:0]         s3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u3_reg <= u2_reg;
            y3_reg <= YW'(rmq_pkg::seed_q8(u2_reg[WB-1:WB-4])) << (WB - 8);
            s3_reg <= side2_reg;
        end
    end

    assign vn[0] = v3_reg;
    assign un[0] = u3_reg;
    assign yn[0] = y3_reg;
    assign sn[0] = s3_reg;

    for (genvar g = 0; g < NI; g++) begin : g_newton
        rmq_newton_stage u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vn[g]),
            .in_u      (un[g]),
            .in_y      (yn[g]),
            .in_side   (sn[g]),
            .out_valid (vn[g+1]),
            .out_u     (un[g+1]),
            .out_y     (yn[g+1]),
            .out_side  (sn[g+1])
        );
    end

    // final stage a: magnitudes times y, registered
    logic                  vf_reg;
    logic [DW-1:0]         sf_reg;
    logic [SW+YW-1:0]      pf_reg [4];
    logic [3:0]            negf_reg;
    logic signed [SW-1:0]  tf, dsel [4];
    logic [DW-1:0]         sfin;
    rmq_pkg::branch_t      brf;
    logic [SW-1:0]         mag [4];
    logic signed [SW-1:0]  fo0, fo1, fo2;

    assign sfin = sn[NI];
    assign tf   = sfin[SW-1:0];
    assign fo0  = sfin[2*SW-1:SW];
    assign fo1  = sfin[3*SW-1:2*SW];
    assign fo2  = sfin[4*SW-1:3*SW];
    assign brf  = rmq_pkg::branch_t'(sfin[4*SW+HW+1:4*SW+HW]);

    always_comb begin
        case (brf)
            rmq_pkg::BR_W: begin
                dsel[0] = tf;  dsel[1] = fo0; dsel[2] = fo1; dsel[3] = fo2;
            end
            rmq_pkg::BR_X: begin
                dsel[0] = fo0; dsel[1] = tf;  dsel[2] = fo1; dsel[3] = fo2;
            end
            rmq_pkg::BR_Y: begin
                dsel[0] = fo0; dsel[1] = fo1; dsel[2] = tf;  dsel[3] = fo2;
            end
            default: begin
                dsel[0] = fo0; dsel[1] = fo1; dsel[2] = fo2; dsel[3] = tf;
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            mag[k] = dsel[k][SW-1] ? SW'(-dsel[k]) : SW'(dsel[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (en) begin
            vf_reg <= vn[NI];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sf_reg <= sfin;
            for (int k = 0; k < 4; k++) begin
                pf_reg[k]   <= (SW+YW)'(mag[k]) * (SW+YW)'(yn[NI]);
                negf_reg[k] <= dsel[k][SW-1];
            end
        end
    end

    // final stage b: round, saturate, output register
    logic [HW:0]          rsh;
    logic                 degf;
    logic [SW+YW:0]       rnd [4];
    logic [15:0]          q [4];
    logic [15:0]          pos_lim, neg_lim;

    assign degf = sf_reg[DW-1];
    assign pos_lim = ((1 << FB) < 32767) ? 16'(1 << FB) : 16'd32767;
    assign neg_lim = ((1 << FB) < 32768) ? 16'(1 << FB) : 16'd32768;

    logic signed [HW-1:0] shr;
    assign shr = sf_reg[4*SW+HW-1:4*SW];
    always_comb begin
        rsh = (HW+1)'(WB + 1) + (HW+1)'((HW'(WB - FB) - shr) >>> 1);
        for (int k = 0; k < 4; k++) begin
            rnd[k] = ((SW+YW+1)'(pf_reg[k]) + ((SW+YW+1)'(1) << (rsh - 1))) >> rsh;
            if (negf_reg[k]) begin
                q[k] = (rnd[k] > (SW+YW+1)'(neg_lim)) ? 16'(-neg_lim) : 16'(-rnd[k]);
            end else begin
                q[k] = (rnd[k] > (SW+YW+1)'(pos_lim)) ? pos_lim : rnd[k][15:0];
            end
            if (degf) q[k] = '0;
        end
    end

    logic [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic        mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (en) begin
            mv_reg <= vf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qw_reg <= q[0];
            qx_reg <= q[1];
            qy_reg <= q[2];
            qz_reg <= q[3];
        end
    end

    assign m_valid  = mv_reg;
    assign m_quat_w = qw_reg;
    assign m_quat_x = qx_reg;
    assign m_quat_y = qy_reg;
    assign m_quat_z = qz_reg;

    `RMQ_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_quat_w), "output changed during stall")
    `RMQ_ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_valid, s_ready, "input blocked with empty output")
    `RMQ_ASSERT_NEXT(a_deg_zero, aclk, aresetn, en && vf_reg && degf, m_quat_x == 16'd0 && m_quat_y == 16'd0, "degenerate sum gave nonzero result")
endmodule

// ===== test/rotation_matrix_to_quaternion_unit_tb.sv =====
// testbench for the rotation matrix to quaternion unit with a self-checking quaternion predictor
module rotation_matrix_to_quaternion_unit_tb;

    localparam int FRAC = rmq_pkg::FRAC_BITS_DEF;
    localparam int NITER = rmq_pkg::RSQRT_ITERATIONS_DEF;
    localparam int WB = rmq_pkg::WORK_BITS;
    localparam int N_RANDOM = 1500;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] w, x, y, z;
    } quat_t;

    typedef logic signed [15:0] mat_t [9];

    function automatic logic [63:0] rsqrt_unit(logic [63:0] u);
        logic [63:0] y, sq, e, f, three;
        y = 64'(rmq_pkg::seed_q8(u[WB-1 -: 4])) << (WB - 8);
        three = 64'd3 << WB;
        for (int i = 0; i < NITER; i++) begin
            sq = (y * y) >> WB;
            e = (sq * u) >> WB;
            f = (e >= three) ? 64'd0 : three - e;
            y = (y * f) >> (WB + 1);
        end
        return y;
    endfunction

    function automatic logic signed [15:0] scale_sat(longint d, logic [63:0] y, int r);
        logic [63:0] mag, p;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        p = (mag * y + (64'd1 << (r - 1))) >> r;
        if (p > 64'd16384) p = 64'd16384;
        return (d < 0) ? -16'(p) : 16'(p);
    endfunction

    function automatic quat_t predict_quat(mat_t m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, t;
        longint d [4];
        rmq_pkg::branch_t br;
        int len, sh, r;
        logic [63:0] u, y;
        quat_t q;
        a00 = m[0]; a01 = m[1]; a02 = m[2];
        a10 = m[3]; a11 = m[4]; a12 = m[5];
        a20 = m[6]; a21 = m[7]; a22 = m[8];
        t = (64'sd1 << FRAC) + a00 + a11 + a22;
        if (t > 0) begin
            br = rmq_pkg::BR_W;
            d[1] = a21 - a12; d[2] = a02 - a20; d[3] = a10 - a01;
        end else if (a00 > a11 && a00 > a22) begin
            br = rmq_pkg::BR_X;
            t = (64'sd1 << FRAC) + a00 - a11 - a22;
            d[0] = a21 - a12; d[2] = a01 + a10; d[3] = a02 + a20;
        end else if (a11 > a22) begin
            br = rmq_pkg::BR_Y;
            t = (64'sd1 << FRAC) + a11 - a00 - a22;
            d[0] = a02 - a20; d[1] = a01 + a10; d[3] = a12 + a21;
        end else begin
            br = rmq_pkg::BR_Z;
            t = (64'sd1 << FRAC) + a22 - a00 - a11;
            d[0] = a10 - a01; d[1] = a02 + a20; d[2] = a12 + a21;
        end
        if (t <= 0) begin
            q.w = 0; q.x = 0; q.y = 0; q.z = 0;
            return q;
        end
        d[br] = t;
        len = 0;
        while ((t >> len) != 0) len++;
        sh = WB - len;
        if ((FRAC + len) % 2 == 1) sh -= 1;
        u = (sh >= 0) ? (64'(t) << sh) : (64'(t) >> (-sh));
        y = rsqrt_unit(u);
        r = WB + 1 + (WB - FRAC - sh) / 2;
        q.w = scale_sat(d[0], y, r);
        q.x = scale_sat(d[1], y, r);
        q.y = scale_sat(d[2], y, r);
        q.z = scale_sat(d[3], y, r);
        return q;
    endfunction

    class quat_scoreboard;
        quat_t pending[$];
        int errors;

        function void note_matrix(mat_t m);
            pending.push_back(predict_quat(m));
        endfunction

        function void check_quat(quat_t got);
            quat_t exp_q;
            if (pending.size() == 0) begin
                $display("%0t unexpected result w=%0d x=%0d y=%0d z=%0d",
                         $time, got.w, got.x, got.y, got.z);
                errors++;
                return;
            end
            exp_q = pending.pop_front();
            if (got.w !== exp_q.w) begin
                $display("%0t quat_w expected %0d actual %0d", $time, exp_q.w, got.w);
                errors++;
            end
            if (got.x !== exp_q.x) begin
                $display("%0t quat_x expected %0d actual %0d", $time, exp_q.x, got.x);
                errors++;
            end
            if (got.y !== exp_q.y) begin
                $display("%0t quat_y expected %0d actual %0d", $time, exp_q.y, got.y);
                errors++;
            end
            if (got.z !== exp_q.z) begin
                $display("%0t quat_z expected %0d actual %0d", $time, exp_q.z, got.z);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [15:0] s_m [9];
    logic m_valid;
    logic m_ready;
    logic signed [15:0] m_quat_w, m_quat_x, m_quat_y, m_quat_z;

    quat_scoreboard sb;
    logic stim_done;
    longint cycles;

    rotation_matrix_to_quaternion_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_m00(s_m[0]), .s_m01(s_m[1]), .s_m02(s_m[2]),
        .s_m10(s_m[3]), .s_m11(s_m[4]), .s_m12(s_m[5]),
        .s_m20(s_m[6]), .s_m21(s_m[7]), .s_m22(s_m[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quat_w(m_quat_w), .m_quat_x(m_quat_x),
        .m_quat_y(m_quat_y), .m_quat_z(m_quat_z)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // valid stays high across back-to-back transfers
    task automatic send_matrix(mat_t m);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid <= 1'b1;
        for (int i = 0; i < 9; i++) s_m[i] <= m[i];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_matrix(m);
        @(negedge aclk);
    endtask

    function automatic logic signed [15:0] rand_elem();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return 16'($signed($urandom_range(0, 32768)) - 16384);
        if (p < 85) return 16'($urandom);
        case ($urandom_range(0, 4))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'h7fff;
            default: return 16'h8000;
        endcase
    endfunction

    // rotation-like matrix with small noise around a signed permutation
    function automatic mat_t rand_rotation();
        mat_t m;
        int perm [3];
        int a, b;
        perm = '{0, 1, 2};
        a = $urandom_range(0, 2); b = $urandom_range(0, 2);
        perm[a] = perm[a] ^ perm[b]; perm[b] = perm[a] ^ perm[b]; perm[a] = perm[a] ^ perm[b];
        if (a == b) perm = '{0, 1, 2};
        for (int i = 0; i < 9; i++)
            m[i] = 16'($signed($urandom_range(0, 12000)) - 6000);
        for (int rr = 0; rr < 3; rr++)
            m[rr * 3 + perm[rr]] = ($urandom_range(0, 1) ? 16'sd1 : -16'sd1)
                                   * 16'($signed($urandom_range(10000, 16384)));
        return m;
    endfunction

    task automatic send_diag(int a, int b, int c);
        mat_t m;
        for (int i = 0; i < 9; i++) m[i] = 0;
        m[0] = 16'(a); m[4] = 16'(b); m[8] = 16'(c);
        send_matrix(m);
    endtask

    initial begin
        mat_t m;
        sb = new();
        stim_done = 0;
        aresetn = 0;
        s_valid = 0;
        for (int i = 0; i < 9; i++) s_m[i] = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // identity and half-turns pick each branch
        send_diag(16384, 16384, 16384);
        send_diag(16384, -16384, -16384);
        send_diag(-16384, 16384, -16384);
        send_diag(-16384, -16384, 16384);
        // trace sum exactly zero, negative and full-scale diagonals, tie on diagonal
        send_diag(-16384, 0, 0);
        send_diag(-16384, -16384, -16384);
        send_diag(-32768, -32768, -32768);
        send_diag(-8192, -8192, -8192);
        send_diag(32767, 32767, 32767);
        send_diag(-16384, -16384, -16384);
        for (int i = 0; i < 9; i++) m[i] = 16'h7fff;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m[i] = 16'h8000;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? -16'sd16384 : 16'h7fff;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? -16'sd16384 : 16'h8000;
        send_matrix(m);
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 99) < 70) m = rand_rotation();
            else for (int i = 0; i < 9; i++) m[i] = rand_elem();
            send_matrix(m);
        end
        s_valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        int g;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        quat_t q;
        if (aresetn && m_valid && m_ready) begin
            q.w = m_quat_w; q.x = m_quat_x; q.y = m_quat_y; q.z = m_quat_z;
            sb.check_quat(q);
        end
    end

    initial begin
        cycles = 0;
        while (!(stim_done && sb.pending.size() == 0) && cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
        end else begin
            repeat (40) @(posedge aclk);
            if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
            else $display("TB_ERROR");
        end
        $finish;
    end

endmodule
